/* src/asw_pkg.sv */
// ============================================================================
// asw_pkg
// Shared types and constants for the fixed-point Adam-style weight update.
// ============================================================================
package asw_pkg;

    // Q8.24 one, the second-moment value after reset
    localparam logic [31:0] Q24_ONE = 32'h0100_0000;

    // step magnitude ceiling, 2^40
    localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

    // register index codes, taken from paddr[4:2]
    localparam logic [2:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [2:0] REG_DECAY_FIRST   = 3'd1;
    localparam logic [2:0] REG_DECAY_SECOND  = 3'd2;
    localparam logic [2:0] REG_EPSILON       = 3'd3;
    localparam logic [2:0] REG_PASS_COUNT    = 3'd4;

    // register reset values
    localparam logic [23:0] LR_RESET   = 24'd16777;
    localparam logic [15:0] B1_RESET   = 16'd58982;
    localparam logic [15:0] B2_RESET   = 16'd58982;
    localparam logic [23:0] EPS_RESET  = 24'd17;
    localparam logic [15:0] PASS_RESET = 16'd0;

    // per-request control carried down the pipe
    // neg: gradient sign before the moment update, first-moment sign after it
    typedef struct packed {
        logic        vld;
        logic        rng;
        logic        neg;
        logic [11:0] idx;
        logic [31:0] old;
    } tag_t;

endpackage

/* src/adam_style_weight_update_top.sv */
// ============================================================================
// adam_style_weight_update_top
// Streaming Adam-style weight update with on-chip first and second moments.
// ============================================================================
// One request enters per clock unless in_stall is high; the rate is set by
// the fully pipelined digit-serial units (gradient average, moment rescale,
// square root and the final multiply-divide), one quotient or root digit per
// stage. Moments live in two single-port-write, registered-read memories
// updated by one read-modify-write stage; back-to-back requests to the same
// index are forwarded. After reset a clearing pass over all NUM_PARAMS
// entries loads the moments (first to zero, second to 1.0) while requests are
// stalled. An output stall holds the whole pipe.
module adam_style_weight_update_top
    import asw_pkg::*;
#(
    parameter int NUM_PARAMS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        param_index,
    input  logic signed [31:0] grad_sum,
    input  logic signed [31:0] old_weight,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_weight,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [23:0] lr_reg;
    logic [15:0] b1_reg;
    logic [15:0] b2_reg;
    logic [23:0] eps_reg;
    logic [15:0] pc_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            b1_reg  <= B1_RESET;
            b2_reg  <= B2_RESET;
            eps_reg <= EPS_RESET;
            pc_reg  <= PASS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_LEARNING_RATE: lr_reg  <= pwdata[23:0];
                REG_DECAY_FIRST:   b1_reg  <= pwdata[15:0];
                REG_DECAY_SECOND:  b2_reg  <= pwdata[15:0];
                REG_EPSILON:       eps_reg <= pwdata[23:0];
                REG_PASS_COUNT:    pc_reg  <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_LEARNING_RATE: prdata = {8'd0, lr_reg};
            REG_DECAY_FIRST:   prdata = {16'd0, b1_reg};
            REG_DECAY_SECOND:  prdata = {16'd0, b2_reg};
            REG_EPSILON:       prdata = {8'd0, eps_reg};
            REG_PASS_COUNT:    prdata = {16'd0, pc_reg};
            default:           prdata = 32'd0;
        endcase
    end

    logic [16:0] d1;
    logic [16:0] d2;
    logic [16:0] pdiv;

    assign d1   = 17'h1_0000 - {1'b0, b1_reg};
    assign d2   = 17'h1_0000 - {1'b0, b2_reg};
    assign pdiv = {1'b0, pc_reg} + 17'd1;

    // ------------------------------------------------------------------------
    // flow control and clearing pass
    // ------------------------------------------------------------------------
    logic          adv;
    logic          out_valid_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = clearing_reg || !adv;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(NUM_PARAMS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // gradient average: |grad| / (pass_count + 1), one quotient bit per stage
    // ------------------------------------------------------------------------
    tag_t        a_tag_reg [0:32];
    logic [31:0] a_num_reg [0:32];
    logic [16:0] a_rem_reg [0:32];
    logic [31:0] a_quo_reg [0:32];
    tag_t        in_tag;

    always_comb
    begin
        in_tag.vld = in_valid && !clearing_reg;
        in_tag.rng = ({20'd0, param_index} < 32'(NUM_PARAMS));
        in_tag.neg = grad_sum[31];
        in_tag.idx = param_index;
        in_tag.old = old_weight;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            a_tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_num_reg[0] <= grad_sum[31] ? 32'(-grad_sum) : grad_sum;
            a_rem_reg[0] <= '0;
            a_quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_avg
        logic [16:0] rem_sh;
        logic [16:0] rem_next;
        logic        ge;

        always_comb
        begin
            rem_sh   = {a_rem_reg[k][15:0], a_num_reg[k][31-k]};
            ge       = (rem_sh >= pdiv);
            rem_next = ge ? rem_sh - pdiv : rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_tag_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                a_tag_reg[k+1] <= a_tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_num_reg[k+1] <= a_num_reg[k];
                a_rem_reg[k+1] <= rem_next;
                a_quo_reg[k+1] <= {a_quo_reg[k][30:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------------
    // square and weighted terms
    // ------------------------------------------------------------------------
    tag_t        p1_tag_reg;
    logic [63:0] p1_sq_reg;
    logic [48:0] p1_km_reg;
    tag_t        p2_tag_reg;
    logic [48:0] p2_km_reg;
    logic [48:0] p2_k2_reg;
    logic [31:0] sq_sat;

    assign sq_sat = (|p1_sq_reg[63:56]) ? 32'hFFFF_FFFF : p1_sq_reg[55:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_tag_reg <= '0;
            p2_tag_reg <= '0;
        end
        else if (adv)
        begin
            p1_tag_reg <= a_tag_reg[32];
            p2_tag_reg <= p1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sq_reg <= 64'(a_quo_reg[32]) * 64'(a_quo_reg[32]);
            p1_km_reg <= 49'(d1) * 49'(a_quo_reg[32]);
            p2_km_reg <= p1_km_reg;
            p2_k2_reg <= 49'(d2) * 49'(sq_sat);
        end
    end

    // ------------------------------------------------------------------------
    // moment memories and read-modify-write stage
    // ------------------------------------------------------------------------
    logic [31:0] m_mem [0:NUM_PARAMS-1];
    logic [31:0] v_mem [0:NUM_PARAMS-1];
    logic [31:0] rd_m_reg;
    logic [31:0] rd_v_reg;

    tag_t        q_tag_reg;
    logic [48:0] q_km_reg;
    logic [48:0] q_k2_reg;

    tag_t        d_tag_reg [0:48];
    logic [31:0] r_m_reg;
    logic [31:0] r_v_reg;

    logic               fwd;
    logic signed [31:0] m_sel;
    logic [31:0]        v_sel;
    logic signed [16:0] b1_s;
    logic signed [50:0] km_s;
    logic signed [50:0] m_sum;
    logic [49:0]        v_sum;
    logic [31:0]        m_new;
    logic [31:0]        v_new;
    logic [31:0]        m_abs;

    always_comb
    begin
        fwd   = d_tag_reg[0].vld && d_tag_reg[0].rng && (d_tag_reg[0].idx == q_tag_reg.idx);
        m_sel = fwd ? r_m_reg : rd_m_reg;
        v_sel = fwd ? r_v_reg : rd_v_reg;
        b1_s  = {1'b0, b1_reg};
        km_s  = q_tag_reg.neg ? -$signed({2'b00, q_km_reg}) : $signed({2'b00, q_km_reg});
        m_sum = 51'(b1_s) * 51'(m_sel) + km_s;
        v_sum = 50'(b2_reg) * 50'(v_sel) + 50'(q_k2_reg);
        m_new = m_sum[47:16];
        v_new = v_sum[47:16];
        m_abs = m_new[31] ? 32'(-$signed(m_new)) : m_new;
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            m_mem[clr_cnt_reg] <= '0;
            v_mem[clr_cnt_reg] <= Q24_ONE;
        end
        else if (adv && q_tag_reg.vld && q_tag_reg.rng)
        begin
            m_mem[AW'(q_tag_reg.idx)] <= m_new;
            v_mem[AW'(q_tag_reg.idx)] <= v_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_m_reg <= m_mem[AW'(p2_tag_reg.idx)];
            rd_v_reg <= v_mem[AW'(p2_tag_reg.idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_tag_reg <= '0;
        end
        else if (adv)
        begin
            q_tag_reg <= p2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_km_reg <= p2_km_reg;
            q_k2_reg <= p2_k2_reg;
            r_m_reg  <= m_new;
            r_v_reg  <= v_new;
        end
    end

    // ------------------------------------------------------------------------
    // moment rescale: m_hat and v_hat, one quotient bit per stage
    // ------------------------------------------------------------------------
    logic [47:0] d_mnum_reg [0:48];
    logic [47:0] d_vnum_reg [0:48];
    logic [16:0] d_mrem_reg [0:48];
    logic [16:0] d_vrem_reg [0:48];
    logic [47:0] d_mquo_reg [0:48];
    logic [47:0] d_vquo_reg [0:48];
    tag_t        r_tag;

    always_comb
    begin
        r_tag     = q_tag_reg;
        r_tag.neg = m_new[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            d_tag_reg[0] <= r_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_mnum_reg[0] <= {m_abs, 16'd0};
            d_vnum_reg[0] <= {v_new, 16'd0};
            d_mrem_reg[0] <= '0;
            d_vrem_reg[0] <= '0;
            d_mquo_reg[0] <= '0;
            d_vquo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < 48; k++)
    begin : g_hat
        logic [16:0] mrem_sh;
        logic [16:0] vrem_sh;
        logic [16:0] mrem_next;
        logic [16:0] vrem_next;
        logic        mge;
        logic        vge;

        always_comb
        begin
            mrem_sh   = {d_mrem_reg[k][15:0], d_mnum_reg[k][47-k]};
            vrem_sh   = {d_vrem_reg[k][15:0], d_vnum_reg[k][47-k]};
            mge       = (mrem_sh >= d1);
            vge       = (vrem_sh >= d2);
            mrem_next = mge ? mrem_sh - d1 : mrem_sh;
            vrem_next = vge ? vrem_sh - d2 : vrem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_tag_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                d_tag_reg[k+1] <= d_tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_mnum_reg[k+1] <= d_mnum_reg[k];
                d_vnum_reg[k+1] <= d_vnum_reg[k];
                d_mrem_reg[k+1] <= mrem_next;
                d_vrem_reg[k+1] <= vrem_next;
                d_mquo_reg[k+1] <= {d_mquo_reg[k][46:0], mge};
                d_vquo_reg[k+1] <= {d_vquo_reg[k][46:0], vge};
            end
        end
    end

    // ------------------------------------------------------------------------
    // square root of v_hat in Q8.24, one root bit per stage
    // ------------------------------------------------------------------------
    tag_t        s_tag_reg  [0:36];
    logic [47:0] s_vh_reg   [0:36];
    logic [47:0] s_mag_reg  [0:36];
    logic [38:0] s_rem_reg  [0:36];
    logic [35:0] s_root_reg [0:36];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            s_tag_reg[0] <= d_tag_reg[48];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_vh_reg[0]   <= d_vquo_reg[48];
            s_mag_reg[0]  <= d_mquo_reg[48];
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < 36; k++)
    begin : g_sqrt
        logic [1:0]  pair;
        logic [38:0] rem_sh;
        logic [38:0] trial;
        logic [38:0] rem_next;
        logic        ge;

        if ((35 - k) >= 12)
        begin : g_pair
            assign pair = s_vh_reg[k][2*(35-k)-24 +: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh   = {s_rem_reg[k][36:0], pair};
            trial    = {1'b0, s_root_reg[k], 2'b01};
            ge       = (rem_sh >= trial);
            rem_next = ge ? rem_sh - trial : rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_tag_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                s_tag_reg[k+1] <= s_tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_vh_reg[k+1]   <= s_vh_reg[k];
                s_mag_reg[k+1]  <= s_mag_reg[k];
                s_rem_reg[k+1]  <= rem_next;
                s_root_reg[k+1] <= {s_root_reg[k][34:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------------
    // step numerator |m_hat| * rate in two partial products, and denominator
    // ------------------------------------------------------------------------
    tag_t        m1_tag_reg;
    logic [36:0] m1_den_reg;
    logic [47:0] m1_ph_reg;
    logic [47:0] m1_pl_reg;
    logic [36:0] den_raw;

    assign den_raw = 37'(s_root_reg[36]) + 37'(eps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_tag_reg <= '0;
        end
        else if (adv)
        begin
            m1_tag_reg <= s_tag_reg[36];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_den_reg <= (den_raw == '0) ? 37'd1 : den_raw;
            m1_ph_reg  <= 48'(s_mag_reg[36][47:24]) * 48'(lr_reg);
            m1_pl_reg  <= 48'(s_mag_reg[36][23:0]) * 48'(lr_reg);
        end
    end

    // ------------------------------------------------------------------------
    // step = numerator / den, capped at 2^40, one quotient bit per stage
    // ------------------------------------------------------------------------
    tag_t        f_tag_reg [0:72];
    logic [71:0] f_num_reg [0:72];
    logic [36:0] f_den_reg [0:72];
    logic [37:0] f_rem_reg [0:72];
    logic [40:0] f_quo_reg [0:72];
    logic        f_ovf_reg [0:72];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            f_tag_reg[0] <= m1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_reg[0] <= {m1_ph_reg, 24'd0} + {24'd0, m1_pl_reg};
            f_den_reg[0] <= m1_den_reg;
            f_rem_reg[0] <= '0;
            f_quo_reg[0] <= '0;
            f_ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar k = 0; k < 72; k++)
    begin : g_step
        logic [37:0] rem_sh;
        logic [37:0] rem_next;
        logic        ge;

        always_comb
        begin
            rem_sh   = {f_rem_reg[k][36:0], f_num_reg[k][71-k]};
            ge       = (rem_sh >= {1'b0, f_den_reg[k]});
            rem_next = ge ? rem_sh - {1'b0, f_den_reg[k]} : rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                f_tag_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                f_tag_reg[k+1] <= f_tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                f_num_reg[k+1] <= f_num_reg[k];
                f_den_reg[k+1] <= f_den_reg[k];
                f_rem_reg[k+1] <= rem_next;
                f_quo_reg[k+1] <= {f_quo_reg[k][39:0], ge};
                f_ovf_reg[k+1] <= f_ovf_reg[k] | f_quo_reg[k][40];
            end
        end
    end

    // ------------------------------------------------------------------------
    // apply step, saturate, output register
    // ------------------------------------------------------------------------
    logic               cap;
    logic [40:0]        step;
    logic signed [42:0] old_x;
    logic signed [42:0] step_x;
    logic signed [42:0] nw;
    logic [31:0]        nw_sat;
    logic [31:0]        new_weight_reg;

    always_comb
    begin
        cap    = f_ovf_reg[72] | f_quo_reg[72][40];
        step   = cap ? STEP_CAP : {1'b0, f_quo_reg[72][39:0]};
        old_x  = 43'($signed(f_tag_reg[72].old));
        step_x = $signed({2'b00, step});
        nw     = f_tag_reg[72].neg ? old_x + step_x : old_x - step_x;
        if (nw[42:31] != {12{nw[42]}})
        begin
            nw_sat = nw[42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            nw_sat = nw[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f_tag_reg[72].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_weight_reg <= f_tag_reg[72].rng ? nw_sat : f_tag_reg[72].old;
        end
    end

    assign new_weight = new_weight_reg;

`ifndef SYNTH
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !q_tag_reg.vld)
        else $error("request in update stage during clearing pass");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(q_tag_reg))
        else $error("update stage moved under output stall");

    a_range_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && f_tag_reg[72].vld && !f_tag_reg[72].rng)
        |=> (new_weight == $past(f_tag_reg[72].old)))
        else $error("out-of-range request changed weight");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Adam-style weight update testbench
// Drives parameter requests over a valid/stall stream, predicts each updated
// weight from a bit-accurate model of the moment stores, and checks every
// result in order. Registers are written over the APB port between phases.
// ============================================================================
module tb
    import asw_pkg::*;
;

    localparam int NPAR = 4096;
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [11:0]        param_index;
    logic signed [31:0] grad_sum;
    logic signed [31:0] old_weight;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] new_weight;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int idle_cycles;
    bit hold_stretch;

    adam_style_weight_update_top dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    class weight_scoreboard;
        logic [23:0] rate;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [23:0] eps;
        logic [15:0] passes;
        logic signed [31:0] mom1[NPAR];
        logic [31:0] mom2[NPAR];
        logic [31:0] pending[$];

        function new();
            rate = LR_RESET;
            b1 = B1_RESET;
            b2 = B2_RESET;
            eps = EPS_RESET;
            passes = PASS_RESET;
            for (int i = 0; i < NPAR; i++)
            begin
                mom1[i] = 0;
                mom2[i] = Q24_ONE;
            end
        endfunction

        function void set_reg(logic [2:0] r, logic [31:0] v);
            case (r)
                REG_LEARNING_RATE: rate = v[23:0];
                REG_DECAY_FIRST:   b1 = v[15:0];
                REG_DECAY_SECOND:  b2 = v[15:0];
                REG_EPSILON:       eps = v[23:0];
                REG_PASS_COUNT:    passes = v[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] root_q24(logic [63:0] vh);
            logic [127:0] x;
            logic [63:0] r;
            x = {64'd0, vh} << 24;
            r = 0;
            for (int b = 40; b >= 0; b--)
                if (({64'd0, r | (64'd1 << b)} * {64'd0, r | (64'd1 << b)}) <= x)
                    r = r | (64'd1 << b);
            return r;
        endfunction

        function void note_request(logic [11:0] idx, logic signed [31:0] g,
                                   logic signed [31:0] old);
            logic [63:0] ga, avga, sq, vnew, mag, vh, s, den;
            logic [127:0] q;
            longint avg, mnew, acc, nw, step;
            if (idx >= NPAR)
            begin
                pending = {pending, old};
                return;
            end
            ga = (g < 0) ? -longint'(g) : longint'(g);
            avga = ga / ({48'd0, passes} + 1);
            avg = (g < 0) ? -longint'(avga) : longint'(avga);
            acc = longint'({48'd0, b1}) * longint'(mom1[idx])
                  + longint'(65536 - {48'd0, b1}) * avg;
            mnew = acc >>> 16;
            mom1[idx] = mnew[31:0];
            sq = (avga * avga) >> 24;
            if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
            vnew = ({48'd0, b2} * {32'd0, mom2[idx]} + (65536 - {48'd0, b2}) * sq) >> 16;
            mom2[idx] = vnew[31:0];
            mag = (((mnew < 0) ? -mnew : mnew) << 16) / (65536 - {48'd0, b1});
            vh = ({32'd0, vnew[31:0]} << 16) / (65536 - {48'd0, b2});
            s = root_q24(vh);
            den = s + {40'd0, eps};
            if (den == 0) den = 1;
            q = ({64'd0, mag} * {104'd0, rate}) / {64'd0, den};
            step = (q >= (128'd1 << 40)) ? (longint'(1) << 40) : longint'(q[63:0]);
            nw = (mnew < 0) ? longint'(old) + step : longint'(old) - step;
            if (nw > 64'sd2147483647) nw = 64'sd2147483647;
            if (nw < -64'sd2147483648) nw = -64'sd2147483648;
            pending = {pending, nw[31:0]};
        endfunction

        task check_result(logic [31:0] got);
            logic [31:0] exp_w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected new_weight %h", got));
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w)
                report($sformatf("new_weight %h, predicted %h", got, exp_w));
        endtask
    endclass

    weight_scoreboard sb;

    task automatic write_reg(input logic [2:0] r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(r, v);
        @(posedge clk);
    endtask

    task automatic send_request(input logic [11:0] idx, input logic [31:0] g,
                                input logic [31:0] w);
        while (idle_cycles > 0 && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        param_index <= idx;
        grad_sum <= g;
        old_weight <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(idx, g, w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (220) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 33554432) - 16777216;
            2: return $urandom_range(0, 4194304) - 2097152;
            default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [11:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(15));
            send_request(idx, rand_grad(), $urandom);
        end
    endtask

    // receiver: random stall, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(new_weight);
            if (hold_stretch)
                out_stall <= 1'b1;
            else
                out_stall <= (idle_cycles > 0) && ($urandom_range(99) < 38);
        end
    end

    int quiet;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 1;
        hold_stretch = 0;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        param_index = '0;
        grad_sum = '0;
        old_weight = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, reset moments, highest index
        send_request(12'd0, 32'h0000_0000, 32'h0000_0000);
        send_request(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(12'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(12'd1, 32'h8000_0000, 32'h8000_0000);
        send_request(12'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(12'd2, 32'h0100_0000, 32'hFFFF_FFFF);
        send_request(12'hFFF, 32'h1234_5678, 32'hDEAD_BEEF);
        send_request(12'd3, 32'hFFFF_FFFF, 32'h0000_0001);
        drain();
        // large step, zero denominator and extremes of every register
        write_reg(REG_LEARNING_RATE, 32'h00FF_FFFF);
        write_reg(REG_DECAY_FIRST, 32'h0000_0000);
        write_reg(REG_DECAY_SECOND, 32'h0000_0000);
        write_reg(REG_EPSILON, 32'h0000_0000);
        write_reg(REG_PASS_COUNT, 32'h0000_0000);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_request(12'd10, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(12'd11, 32'h0000_0000, 32'h1000_0000);
        send_request(12'd12, 32'h8000_0000, 32'h7000_0000);
        send_request(12'd13, 32'h0000_0001, 32'h0);
        drain();
        write_reg(REG_DECAY_FIRST, 32'h0000_FFFF);
        write_reg(REG_DECAY_SECOND, 32'h0000_FFFF);
        write_reg(REG_EPSILON, 32'h00FF_FFFF);
        write_reg(REG_PASS_COUNT, 32'h0000_FFFF);
        write_reg(REG_LEARNING_RATE, 32'h0000_0000);
        send_request(12'd20, 32'h7FFF_FFFF, 32'h0000_0100);
        send_request(12'd20, 32'h8000_0000, 32'hFFFF_FF00);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_LEARNING_RATE, $urandom_range(24'hFFFFFF));
            write_reg(REG_DECAY_FIRST, $urandom_range(16'hFFFF));
            write_reg(REG_DECAY_SECOND, $urandom_range(16'hFFFF));
            write_reg(REG_EPSILON, $urandom_range(3) == 0 ? 0 : $urandom_range(24'hFFFFFF));
            write_reg(REG_PASS_COUNT, $urandom_range(3) == 0 ? 0 : $urandom_range(16'hFFFF));
            idle_cycles = (ph == 2) ? 0 : 1;
            if (ph == 3)
            begin
                fork
                    begin
                        hold_stretch = 1;
                        repeat (600) @(posedge clk);
                        hold_stretch = 0;
                    end
                join_none
            end
            random_phase(220);
            drain();
        end
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
